// ----- rtl/drsh_pkg.sv -----
// package for the double rolling substring hash block
// types, constants and a helper function used by every rtl file but drsh_ram
`timescale 1ns / 1ps

package drsh_pkg;

  localparam int unsigned MaxLen  = 4096;
  localparam int unsigned ResW    = 30;
  localparam int unsigned HashW   = 2 * ResW;
  localparam int unsigned CharW   = 8;
  localparam int unsigned IdxW    = 12;
  localparam int unsigned PosMaxW = 16;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [ResW-1:0] ModFirst  = 30'd1000015553;
  localparam logic [ResW-1:0] ModSecond = 30'd1000028537;
  localparam logic [ResW-1:0] BaseReset = 30'd1000;

  localparam logic OpAppend = 1'b0;
  localparam logic OpQuery  = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgBaseFirst  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBaseSecond = 1'b1;

  typedef enum logic [1:0] {
    KIND_APPEND,
    KIND_QUERY,
    KIND_ERROR
  } kind_e;

  typedef struct packed {
    kind_e                    kind;
    logic [CharW-1:0]         char_value;
    logic [IdxW-1:0]          left;
    logic [IdxW-1:0]          right;
    logic [PosMaxW-1:0]       pos;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APP_WAIT,
    ST_Q_RD1,
    ST_Q_RD2,
    ST_Q_RD3,
    ST_Q_WAIT,
    ST_RESULT
  } back_state_e;

  // one compare and subtract, valid for s below twice p
  function automatic logic [ResW-1:0] mod_fix(logic [ResW:0] s, logic [ResW-1:0] p);
    logic [ResW:0] d;
    d = s - {1'b0, p};
    return (s >= {1'b0, p}) ? d[ResW-1:0] : s[ResW-1:0];
  endfunction

endpackage

// ----- rtl/drsh_ram.sv -----
// generic single write, single read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module drsh_ram #(
  parameter int unsigned Width = 60,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/drsh_modmul.sv -----
// pipelined modular multiplier, barrett reduction
// uses drsh_pkg
`timescale 1ns / 1ps

module drsh_modmul #(
  parameter logic [drsh_pkg::ResW-1:0] Modulus = drsh_pkg::ModFirst
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [drsh_pkg::ResW-1:0] a_i,
  input  logic [drsh_pkg::ResW-1:0] b_i,
  output logic                      out_valid_o,
  output logic [drsh_pkg::ResW-1:0] r_o
);

  localparam int unsigned N = drsh_pkg::ResW;
  localparam logic [63:0] BarM64 = (64'd1 << (2 * N)) / {34'd0, Modulus};
  localparam logic [N:0] BarM = BarM64[N:0];
  localparam logic [N+1:0] ModW = {2'b00, Modulus};
  localparam logic [N+1:0] Mod2W = {1'b0, Modulus, 1'b0};

  logic [4:0]       vld_q;
  logic [2*N-1:0]   x_q;
  logic [2*N-1:0]   x1_q;
  logic [2*N-1:0]   x2_q;
  logic [2*N+1:0]   qm_q;
  logic [2*N:0]     qp_q;
  logic [N+1:0]     r_q;
  logic [N-1:0]     res_q;
  logic [N:0]       quot;
  logic [N+1:0]     r_m1;
  logic [N+1:0]     r_m2;

  assign quot = qm_q[2*N+1:N+1];
  assign r_m1 = r_q - ModW;
  assign r_m2 = r_q - Mod2W;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= a_i * b_i;
    qm_q <= x_q[2*N-1:N-1] * BarM;
    x1_q <= x_q;
    qp_q <= quot * Modulus;
    x2_q <= x1_q;
    r_q  <= x2_q[N+1:0] - qp_q[N+1:0];
    if (r_q >= Mod2W) begin
      res_q <= r_m2[N-1:0];
    end else if (r_q >= ModW) begin
      res_q <= r_m1[N-1:0];
    end else begin
      res_q <= r_q[N-1:0];
    end
  end

  assign out_valid_o = vld_q[4];
  assign r_o         = res_q;

endmodule

// ----- rtl/drsh_front.sv -----
// front end: accepts items, tracks loaded length, checks query ranges
// uses drsh_pkg, feeds drsh_queue
`timescale 1ns / 1ps

module drsh_front #(
  parameter int unsigned MaxLen = drsh_pkg::MaxLen
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       operation_i,
  input  logic                       restart_i,
  input  logic [drsh_pkg::CharW-1:0] char_value_i,
  input  logic [drsh_pkg::IdxW-1:0]  left_index_i,
  input  logic [drsh_pkg::IdxW-1:0]  right_index_i,
  input  logic                       full_i,
  output logic                       push_o,
  output drsh_pkg::entry_t           entry_o
);

  localparam int unsigned LW = $clog2(MaxLen + 1);
  localparam int unsigned CW = (LW > drsh_pkg::IdxW) ? LW : drsh_pkg::IdxW;

  logic [LW-1:0] len_q;
  logic [LW-1:0] len_d;
  logic          accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    len_d              = len_q;
    push_o             = 1'b0;
    entry_o.kind       = drsh_pkg::KIND_APPEND;
    entry_o.char_value = char_value_i;
    entry_o.left       = left_index_i;
    entry_o.right      = right_index_i;
    entry_o.pos        = '0;
    if (accept) begin
      if (operation_i == drsh_pkg::OpQuery) begin
        push_o = 1'b1;
        if ((left_index_i > right_index_i) || (CW'(right_index_i) >= CW'(len_q))) begin
          entry_o.kind = drsh_pkg::KIND_ERROR;
        end else begin
          entry_o.kind = drsh_pkg::KIND_QUERY;
        end
      end else if (restart_i) begin
        push_o = 1'b1;
        len_d  = LW'(1);
      end else if (len_q != LW'(MaxLen)) begin
        push_o      = 1'b1;
        entry_o.pos = drsh_pkg::PosMaxW'(len_q);
        len_d       = len_q + LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

endmodule

// ----- rtl/drsh_queue.sv -----
// two entry queue between front end and back end
// uses drsh_pkg
`timescale 1ns / 1ps

module drsh_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  drsh_pkg::entry_t entry_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output drsh_pkg::entry_t head_o
);

  drsh_pkg::entry_t slot_q [2];
  logic             wr_q;
  logic             rd_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

endmodule

// ----- rtl/drsh_back.sv -----
// back end: builds prefix and power tables, answers substring queries
// uses drsh_pkg, drsh_ram, drsh_modmul
`timescale 1ns / 1ps

module drsh_back #(
  parameter int unsigned MaxLen = drsh_pkg::MaxLen
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       empty_i,
  input  drsh_pkg::entry_t           head_i,
  output logic                       pop_o,
  input  logic [drsh_pkg::ResW-1:0]  base_first_i,
  input  logic [drsh_pkg::ResW-1:0]  base_second_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [drsh_pkg::HashW-1:0] hash_value_o,
  output logic                       range_error_o
);

  localparam int unsigned AW   = $clog2(MaxLen);
  localparam int unsigned RW   = drsh_pkg::ResW;
  localparam int unsigned HW   = drsh_pkg::HashW;
  localparam int unsigned SumW = RW + 1;
  localparam int unsigned IW   = drsh_pkg::IdxW;

  drsh_pkg::back_state_e state_q, state_d;
  drsh_pkg::entry_t      ent_q, ent_d;

  logic [RW-1:0] last_h1_q, last_h1_d, last_h2_q, last_h2_d;
  logic [RW-1:0] last_p1_q, last_p1_d, last_p2_q, last_p2_d;
  logic [HW-1:0] hprev_q, hprev_d, pwlen_q, pwlen_d, hj_q, hj_d, res_q, res_d;
  logic          err_q, err_d;
  logic          out_valid_q, out_valid_d;
  logic [HW-1:0] out_hash_q, out_hash_d;
  logic          out_err_q, out_err_d;

  logic          we;
  logic [AW-1:0] waddr, raddr_pre, raddr_pow;
  logic [HW-1:0] wdata_pre, wdata_pow, rdata_pre, rdata_pow;

  logic          issue_app, issue_q, issue_h;
  logic [RW-1:0] mh_a1, mh_b1, mh_a2, mh_b2;
  logic          mp1_vld, mp2_vld, mh1_vld, mh2_vld;
  logic [RW-1:0] mp1_r, mp2_r, mh1_r, mh2_r;

  logic [IW-1:0] left_m1, span;
  logic [RW-1:0] h1_new, h2_new, q1, q2;

  drsh_ram #(.Width(HW), .Depth(MaxLen)) u_prefix_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata_pre),
    .raddr_i(raddr_pre),
    .rdata_o(rdata_pre)
  );

  drsh_ram #(.Width(HW), .Depth(MaxLen)) u_power_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata_pow),
    .raddr_i(raddr_pow),
    .rdata_o(rdata_pow)
  );

  assign issue_h = issue_app || issue_q;
  assign mh_a1   = issue_q ? hprev_q[HW-1:RW] : last_h1_q;
  assign mh_b1   = issue_q ? pwlen_q[HW-1:RW] : base_first_i;
  assign mh_a2   = issue_q ? hprev_q[RW-1:0]  : last_h2_q;
  assign mh_b2   = issue_q ? pwlen_q[RW-1:0]  : base_second_i;

  drsh_modmul #(.Modulus(drsh_pkg::ModFirst)) u_mm_pow_first (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(issue_app),
    .a_i(last_p1_q), .b_i(base_first_i), .out_valid_o(mp1_vld), .r_o(mp1_r)
  );

  drsh_modmul #(.Modulus(drsh_pkg::ModSecond)) u_mm_pow_second (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(issue_app),
    .a_i(last_p2_q), .b_i(base_second_i), .out_valid_o(mp2_vld), .r_o(mp2_r)
  );

  drsh_modmul #(.Modulus(drsh_pkg::ModFirst)) u_mm_hash_first (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(issue_h),
    .a_i(mh_a1), .b_i(mh_b1), .out_valid_o(mh1_vld), .r_o(mh1_r)
  );

  drsh_modmul #(.Modulus(drsh_pkg::ModSecond)) u_mm_hash_second (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(issue_h),
    .a_i(mh_a2), .b_i(mh_b2), .out_valid_o(mh2_vld), .r_o(mh2_r)
  );

  assign left_m1 = ent_q.left - IW'(1);
  assign span    = ent_q.right - ent_q.left + IW'(1);

  assign h1_new = drsh_pkg::mod_fix({1'b0, mh1_r} + SumW'(ent_q.char_value),
                                    drsh_pkg::ModFirst);
  assign h2_new = drsh_pkg::mod_fix({1'b0, mh2_r} + SumW'(ent_q.char_value),
                                    drsh_pkg::ModSecond);
  assign q1 = drsh_pkg::mod_fix({1'b0, hj_q[HW-1:RW]} + {1'b0, drsh_pkg::ModFirst}
                                - {1'b0, mh1_r}, drsh_pkg::ModFirst);
  assign q2 = drsh_pkg::mod_fix({1'b0, hj_q[RW-1:0]} + {1'b0, drsh_pkg::ModSecond}
                                - {1'b0, mh2_r}, drsh_pkg::ModSecond);

  always_comb begin
    state_d     = state_q;
    ent_d       = ent_q;
    last_h1_d   = last_h1_q;
    last_h2_d   = last_h2_q;
    last_p1_d   = last_p1_q;
    last_p2_d   = last_p2_q;
    hprev_d     = hprev_q;
    pwlen_d     = pwlen_q;
    hj_d        = hj_q;
    res_d       = res_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_hash_d  = out_hash_q;
    out_err_d   = out_err_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    waddr       = AW'(ent_q.pos);
    wdata_pre   = {h1_new, h2_new};
    wdata_pow   = {mp1_r, mp2_r};
    raddr_pre   = AW'(left_m1);
    raddr_pow   = AW'(span);
    issue_app   = 1'b0;
    issue_q     = 1'b0;
    unique case (state_q)
      drsh_pkg::ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          ent_d = head_i;
          unique case (head_i.kind)
            drsh_pkg::KIND_APPEND: begin
              if (head_i.pos == '0) begin
                we        = 1'b1;
                waddr     = '0;
                wdata_pre = {RW'(head_i.char_value), RW'(head_i.char_value)};
                wdata_pow = {RW'(1), RW'(1)};
                last_h1_d = RW'(head_i.char_value);
                last_h2_d = RW'(head_i.char_value);
                last_p1_d = RW'(1);
                last_p2_d = RW'(1);
              end else begin
                issue_app = 1'b1;
                state_d   = drsh_pkg::ST_APP_WAIT;
              end
            end
            drsh_pkg::KIND_QUERY: begin
              state_d = drsh_pkg::ST_Q_RD1;
            end
            drsh_pkg::KIND_ERROR: begin
              res_d   = '0;
              err_d   = 1'b1;
              state_d = drsh_pkg::ST_RESULT;
            end
            default: begin
              state_d = drsh_pkg::ST_IDLE;
            end
          endcase
        end
      end
      drsh_pkg::ST_APP_WAIT: begin
        if (mp1_vld && mp2_vld && mh1_vld && mh2_vld) begin
          we        = 1'b1;
          last_h1_d = h1_new;
          last_h2_d = h2_new;
          last_p1_d = mp1_r;
          last_p2_d = mp2_r;
          state_d   = drsh_pkg::ST_IDLE;
        end
      end
      drsh_pkg::ST_Q_RD1: begin
        state_d = drsh_pkg::ST_Q_RD2;
      end
      drsh_pkg::ST_Q_RD2: begin
        raddr_pre = AW'(ent_q.right);
        hprev_d   = rdata_pre;
        pwlen_d   = rdata_pow;
        state_d   = drsh_pkg::ST_Q_RD3;
      end
      drsh_pkg::ST_Q_RD3: begin
        hj_d = rdata_pre;
        if (ent_q.left == '0) begin
          res_d   = rdata_pre;
          err_d   = 1'b0;
          state_d = drsh_pkg::ST_RESULT;
        end else begin
          issue_q = 1'b1;
          state_d = drsh_pkg::ST_Q_WAIT;
        end
      end
      drsh_pkg::ST_Q_WAIT: begin
        if (mh1_vld && mh2_vld) begin
          res_d   = {q1, q2};
          err_d   = 1'b0;
          state_d = drsh_pkg::ST_RESULT;
        end
      end
      drsh_pkg::ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_hash_d  = res_q;
          out_err_d   = err_q;
          state_d     = drsh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = drsh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= drsh_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q      <= ent_d;
    last_h1_q  <= last_h1_d;
    last_h2_q  <= last_h2_d;
    last_p1_q  <= last_p1_d;
    last_p2_q  <= last_p2_d;
    hprev_q    <= hprev_d;
    pwlen_q    <= pwlen_d;
    hj_q       <= hj_d;
    res_q      <= res_d;
    err_q      <= err_d;
    out_hash_q <= out_hash_d;
    out_err_q  <= out_err_d;
  end

  assign out_valid_o   = out_valid_q;
  assign hash_value_o  = out_hash_q;
  assign range_error_o = out_err_q;

endmodule

// ----- rtl/double_rolling_substring_hash_top.sv -----
// Double polynomial rolling hash over substrings, moduli 1000015553 and 1000028537.
// Appends build prefix-hash and power tables one character at a time; a query
// returns (r1 << 30) ^ r2 for [left, right], or zero with range_error set.
// Config register 0 is base_first and register 1 is base_second, both reset to
// 1000; write them only while the block is idle. The front end checks ranges
// and feeds a two-entry queue, so input is accepted while the back end works.
// In the back end an append at position 0 is written directly, and any other
// append waits on the five-stage Barrett modular multiplier; a query reads the
// single read port of the prefix memory at left-1 and then at right, and when
// left is not 0 it also waits on the multiplier before the output register is
// loaded. No clearing pass is needed after reset.
`timescale 1ns / 1ps

module double_rolling_substring_hash_top #(
  parameter int unsigned MaxLen = drsh_pkg::MaxLen
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [drsh_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [drsh_pkg::ResW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         operation_i,
  input  logic                         restart_i,
  input  logic [drsh_pkg::CharW-1:0]   char_value_i,
  input  logic [drsh_pkg::IdxW-1:0]    left_index_i,
  input  logic [drsh_pkg::IdxW-1:0]    right_index_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [drsh_pkg::HashW-1:0]   hash_value_o,
  output logic                         range_error_o
);

  logic [drsh_pkg::ResW-1:0] base_first_q, base_second_q;
  logic                      push, pop, full, empty;
  drsh_pkg::entry_t          push_entry, head_entry;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_first_q  <= drsh_pkg::BaseReset;
      base_second_q <= drsh_pkg::BaseReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        drsh_pkg::CfgBaseFirst:  base_first_q  <= cfg_data_i;
        drsh_pkg::CfgBaseSecond: base_second_q <= cfg_data_i;
        default: base_first_q <= base_first_q;
      endcase
    end
  end

  drsh_front #(.MaxLen(MaxLen)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .restart_i    (restart_i),
    .char_value_i (char_value_i),
    .left_index_i (left_index_i),
    .right_index_i(right_index_i),
    .full_i       (full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  drsh_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .pop_i  (pop),
    .full_o (full),
    .empty_o(empty),
    .head_o (head_entry)
  );

  drsh_back #(.MaxLen(MaxLen)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (head_entry),
    .pop_o        (pop),
    .base_first_i (base_first_q),
    .base_second_i(base_second_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_value_o (hash_value_o),
    .range_error_o(range_error_o)
  );

endmodule

// ----- tb/sv/testbench.sv -----
// testbench for double_rolling_substring_hash_top: directed table, then random phases
// with base changes, checked against a local prefix-hash predictor; needs drsh_pkg
`timescale 1ns / 1ps

module testbench;

  localparam longint unsigned CycleLimit = 2000000;
  localparam int unsigned     SettleCycles = 40;

  typedef struct {
    logic                       op;
    logic                       rs;
    logic [drsh_pkg::CharW-1:0] ch;
    logic [drsh_pkg::IdxW-1:0]  lft;
    logic [drsh_pkg::IdxW-1:0]  rgt;
    bit                         typed;
    logic [drsh_pkg::HashW-1:0] hash;
    logic                       err;
  } req_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [drsh_pkg::CfgIdxW-1:0] cfg_index_i = drsh_pkg::CfgBaseFirst;
  logic [drsh_pkg::ResW-1:0]    cfg_data_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic                         operation_i = drsh_pkg::OpAppend;
  logic                         restart_i = 1'b0;
  logic [drsh_pkg::CharW-1:0]   char_value_i = '0;
  logic [drsh_pkg::IdxW-1:0]    left_index_i = '0;
  logic [drsh_pkg::IdxW-1:0]    right_index_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [drsh_pkg::HashW-1:0]   hash_value_o;
  logic                         range_error_o;

  double_rolling_substring_hash_top dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [drsh_pkg::ResW-1:0] pfx_a [drsh_pkg::MaxLen];
  logic [drsh_pkg::ResW-1:0] pfx_b [drsh_pkg::MaxLen];
  logic [drsh_pkg::ResW-1:0] pow_a [drsh_pkg::MaxLen];
  logic [drsh_pkg::ResW-1:0] pow_b [drsh_pkg::MaxLen];
  int unsigned               str_len;
  logic [drsh_pkg::ResW-1:0] base_a, base_b;

  logic [drsh_pkg::HashW-1:0] hash_q [$];
  logic                       err_q [$];
  int unsigned                errors;
  longint unsigned            cycles;
  bit                         in_idle_en, out_stall_en;
  req_row_t                   dir_tab [$];

  function automatic longint unsigned mulmod(longint unsigned a, longint unsigned b,
                                             longint unsigned p);
    return ((a & 64'h3FFFFFFF) * (b & 64'h3FFFFFFF)) % p;
  endfunction

  function automatic longint unsigned sub_res(longint unsigned hj, longint unsigned hp,
                                              longint unsigned pw, longint unsigned p);
    longint unsigned t;
    t = mulmod(hp, pw, p);
    return ((hj % p) + p - t) % p;
  endfunction

  // applies one request to the hash tables, returns 1 when a result is due
  function automatic bit hash_predict(logic op, logic rs, logic [drsh_pkg::CharW-1:0] ch,
                                      logic [drsh_pkg::IdxW-1:0] l,
                                      logic [drsh_pkg::IdxW-1:0] r,
                                      output logic [drsh_pkg::HashW-1:0] h,
                                      output logic e);
    longint unsigned pa, pb, r1, r2;
    int unsigned k, n;
    pa = 64'(drsh_pkg::ModFirst);
    pb = 64'(drsh_pkg::ModSecond);
    h = '0;
    e = 1'b0;
    if (op == drsh_pkg::OpAppend) begin
      if (rs) str_len = 0;
      if (str_len >= drsh_pkg::MaxLen) return 1'b0;
      k = str_len;
      if (k == 0) begin
        pow_a[0] = drsh_pkg::ResW'(1);
        pow_b[0] = drsh_pkg::ResW'(1);
        pfx_a[0] = drsh_pkg::ResW'(ch);
        pfx_b[0] = drsh_pkg::ResW'(ch);
      end else begin
        pow_a[k] = drsh_pkg::ResW'(mulmod(64'(base_a), 64'(pow_a[k-1]), pa));
        pow_b[k] = drsh_pkg::ResW'(mulmod(64'(base_b), 64'(pow_b[k-1]), pb));
        pfx_a[k] = drsh_pkg::ResW'((mulmod(64'(pfx_a[k-1]), 64'(base_a), pa) + 64'(ch)) % pa);
        pfx_b[k] = drsh_pkg::ResW'((mulmod(64'(pfx_b[k-1]), 64'(base_b), pb) + 64'(ch)) % pb);
      end
      str_len = k + 1;
      return 1'b0;
    end
    if (l > r || r >= str_len) begin
      e = 1'b1;
      return 1'b1;
    end
    if (l == 0) begin
      r1 = 64'(pfx_a[r]);
      r2 = 64'(pfx_b[r]);
    end else begin
      n = r - l + 1;
      r1 = sub_res(64'(pfx_a[r]), 64'(pfx_a[l-1]), 64'(pow_a[n]), pa);
      r2 = sub_res(64'(pfx_b[r]), 64'(pfx_b[l-1]), 64'(pow_b[n]), pb);
    end
    h = drsh_pkg::HashW'(((r1 & 64'h3FFFFFFF) << 30) ^ (r2 & 64'h3FFFFFFF));
    return 1'b1;
  endfunction

  task automatic report(string what, logic [drsh_pkg::HashW-1:0] got,
                        logic [drsh_pkg::HashW-1:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL double_rolling_substring_hash_top");
      $finish;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (hash_q.size() == 0) begin
        report("unexpected result", hash_value_o, '0);
      end else begin
        if (hash_value_o !== hash_q[0]) report("hash_value", hash_value_o, hash_q[0]);
        if (range_error_o !== err_q[0]) begin
          report("range_error", drsh_pkg::HashW'(range_error_o), drsh_pkg::HashW'(err_q[0]));
        end
        void'(hash_q.pop_front());
        void'(err_q.pop_front());
      end
    end
  end

  // result side stalls
  initial begin
    @(posedge rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      if (out_stall_en) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  task automatic write_base(logic [drsh_pkg::CfgIdxW-1:0] idx,
                            logic [drsh_pkg::ResW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == drsh_pkg::CfgBaseFirst) base_a = val;
    else base_b = val;
  endtask

  task automatic send(req_row_t rq);
    logic [drsh_pkg::HashW-1:0] h;
    logic                       e;
    if (in_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= rq.op;
    restart_i     <= rq.rs;
    char_value_i  <= rq.ch;
    left_index_i  <= rq.lft;
    right_index_i <= rq.rgt;
    do @(posedge clk_i); while (!in_ready_o);
    if (hash_predict(rq.op, rq.rs, rq.ch, rq.lft, rq.rgt, h, e)) begin
      hash_q.push_back(rq.typed ? rq.hash : h);
      err_q.push_back(rq.typed ? rq.err : e);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (hash_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic req_row_t mk(logic op, logic rs, logic [drsh_pkg::CharW-1:0] ch,
                                  logic [drsh_pkg::IdxW-1:0] l,
                                  logic [drsh_pkg::IdxW-1:0] r,
                                  bit typed = 0, logic [drsh_pkg::HashW-1:0] h = '0,
                                  logic e = 1'b0);
    req_row_t rq;
    rq = '{op, rs, ch, l, r, typed, h, e};
    return rq;
  endfunction

  function automatic req_row_t rand_req();
    logic [drsh_pkg::CharW-1:0] ch;
    int unsigned sel, l, r;
    sel = $urandom_range(0, 99);
    ch = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) != 0 ? 8'hFF : 8'h00)
                                     : drsh_pkg::CharW'($urandom);
    if (str_len == 0 || sel < 50)
      return mk(drsh_pkg::OpAppend, $urandom_range(0, 19) == 0, ch,
                drsh_pkg::IdxW'($urandom), drsh_pkg::IdxW'($urandom));
    if (sel < 88) begin
      r = $urandom_range(0, str_len - 1);
      l = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, r);
      return mk(drsh_pkg::OpQuery, 1'($urandom_range(0, 1)), ch,
                drsh_pkg::IdxW'(l), drsh_pkg::IdxW'(r));
    end
    return mk(drsh_pkg::OpQuery, 1'($urandom_range(0, 1)), ch,
              drsh_pkg::IdxW'($urandom), drsh_pkg::IdxW'($urandom));
  endfunction

  task automatic random_phase(int unsigned n);
    repeat (n) send(rand_req());
    settle();
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    str_len = 0;
    base_a = drsh_pkg::BaseReset;
    base_b = drsh_pkg::BaseReset;
    in_idle_en = 1'b1;
    out_stall_en = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at reset bases
    dir_tab.push_back(mk(drsh_pkg::OpQuery,  1'b0, 8'h00, 12'd0, 12'd0, 1, '0, 1'b1));
    dir_tab.push_back(mk(drsh_pkg::OpAppend, 1'b1, 8'hFF, 12'hFFF, 12'hFFF));
    dir_tab.push_back(mk(drsh_pkg::OpQuery,  1'b0, 8'h00, 12'd0, 12'd0, 1,
                         (60'hFF << 30) ^ 60'hFF, 1'b0));
    dir_tab.push_back(mk(drsh_pkg::OpAppend, 1'b0, 8'h00, 12'd5, 12'd1));
    dir_tab.push_back(mk(drsh_pkg::OpAppend, 1'b0, 8'hA5, 12'd0, 12'd0));
    dir_tab.push_back(mk(drsh_pkg::OpAppend, 1'b0, 8'h7F, 12'hFFF, 12'd0));
    dir_tab.push_back(mk(drsh_pkg::OpQuery,  1'b0, 8'h00, 12'd0, 12'd3));
    dir_tab.push_back(mk(drsh_pkg::OpQuery,  1'b1, 8'hFF, 12'd1, 12'd3));
    dir_tab.push_back(mk(drsh_pkg::OpQuery,  1'b0, 8'h00, 12'd3, 12'd3));
    dir_tab.push_back(mk(drsh_pkg::OpQuery,  1'b0, 8'h00, 12'd1, 12'd1));
    dir_tab.push_back(mk(drsh_pkg::OpQuery,  1'b0, 8'h00, 12'd2, 12'd1, 1, '0, 1'b1));
    dir_tab.push_back(mk(drsh_pkg::OpQuery,  1'b0, 8'h00, 12'd0, 12'd4, 1, '0, 1'b1));
    dir_tab.push_back(mk(drsh_pkg::OpQuery,  1'b0, 8'h00, 12'hFFF, 12'hFFF, 1, '0, 1'b1));
    dir_tab.push_back(mk(drsh_pkg::OpQuery,  1'b0, 8'h00, 12'hFFF, 12'd0, 1, '0, 1'b1));
    dir_tab.push_back(mk(drsh_pkg::OpAppend, 1'b1, 8'h5A, 12'hFFF, 12'hFFF));
    dir_tab.push_back(mk(drsh_pkg::OpQuery,  1'b1, 8'hFF, 12'd0, 12'd0, 1,
                         (60'h5A << 30) ^ 60'h5A, 1'b0));
    dir_tab.push_back(mk(drsh_pkg::OpQuery,  1'b0, 8'h00, 12'd0, 12'd1, 1, '0, 1'b1));
    dir_tab.push_back(mk(drsh_pkg::OpAppend, 1'b0, 8'h00, 12'd0, 12'd0));
    dir_tab.push_back(mk(drsh_pkg::OpQuery,  1'b0, 8'h00, 12'd1, 12'd1));
    dir_tab.push_back(mk(drsh_pkg::OpQuery,  1'b0, 8'h00, 12'd0, 12'd1));
    foreach (dir_tab[k]) send(dir_tab[k]);
    settle();

    // base settings: low extreme, modulus minus one, all ones and modulus, random
    write_base(drsh_pkg::CfgBaseFirst, drsh_pkg::ResW'(356));
    write_base(drsh_pkg::CfgBaseSecond, drsh_pkg::ResW'(356));
    random_phase(300);
    write_base(drsh_pkg::CfgBaseFirst, drsh_pkg::ModFirst - drsh_pkg::ResW'(1));
    write_base(drsh_pkg::CfgBaseSecond, drsh_pkg::ModSecond - drsh_pkg::ResW'(1));
    random_phase(300);
    write_base(drsh_pkg::CfgBaseFirst, '1);
    write_base(drsh_pkg::CfgBaseSecond, drsh_pkg::ModSecond);
    random_phase(300);
    write_base(drsh_pkg::CfgBaseFirst, drsh_pkg::ResW'($urandom_range(356, 1000015552)));
    write_base(drsh_pkg::CfgBaseSecond, drsh_pkg::ResW'($urandom_range(356, 1000028536)));
    random_phase(300);

    write_base(drsh_pkg::CfgBaseFirst, drsh_pkg::ResW'($urandom_range(356, 1000015552)));
    write_base(drsh_pkg::CfgBaseSecond, drsh_pkg::ResW'($urandom_range(356, 1000028536)));
    random_phase(300);
    write_base(drsh_pkg::CfgBaseSecond, drsh_pkg::BaseReset);
    random_phase(200);

    in_idle_en = 1'b0;
    out_stall_en = 1'b0;
    random_phase(200);

    if (errors == 0) begin
      $display("PASS double_rolling_substring_hash_top");
    end else begin
      $display("FAIL double_rolling_substring_hash_top");
    end
    $finish;
  end

endmodule
